// File: rtl/nads_pkg.sv
// Shared types and constants for the nesting-aware delimiter splitter.
package nads_pkg;

	localparam int CFG_IDX_BITS = 2;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		CFG_DELIMITER  = 2'd0,
		CFG_LIST_OPEN  = 2'd1,
		CFG_LIST_CLOSE = 2'd2,
		CFG_UNUSED     = 2'd3
	} cfg_idx_t;

	localparam logic [7:0] RST_DELIMITER  = 8'd44;
	localparam logic [7:0] RST_LIST_OPEN  = 8'd91;
	localparam logic [7:0] RST_LIST_CLOSE = 8'd93;

	localparam logic [7:0] CH_BRACE_OPEN  = 8'h7B;
	localparam logic [7:0] CH_BRACE_CLOSE = 8'h7D;
	localparam logic [7:0] CH_SQUOTE      = 8'h27;
	localparam logic [7:0] CH_DQUOTE      = 8'h22;

	typedef struct packed {
		logic [7:0] delimiter;
		logic [7:0] list_open;
		logic [7:0] list_close;
	} cfg_t;

	typedef struct packed {
		logic [7:0]  ch;
		logic [15:0] position;
		logic        first;
		logic        last;
		logic        empty_req;
	} item_t;

	typedef struct packed {
		logic [15:0] start;
		logic [15:0] length;
		logic        fin;
	} seg_t;

	typedef struct packed {
		logic [1:0] count;
		seg_t       seg0;
		seg_t       seg1;
	} scan_res_t;

endpackage

// File: rtl/nesting_aware_delimiter_splitter.sv
// Top level of the nesting-aware delimiter splitter.
//
// Input channel (in_valid/in_ready) takes one character item per cycle while
// in_ready is high, with its position and the first, last and empty_req
// marks. Output channel (out_valid/out_ready) hands out segments (seg_start,
// seg_length, final_segment) one per cycle while out_ready is high, in order.
// An accepted item is held in the input register until the queue has room;
// then an edge updates the nesting state and pushes its zero, one or two
// segments into a four-entry result queue, from whose head out_valid offers
// the first segment.
// The input register takes one item per cycle while the queue has room; the
// single output port limits the rate to one segment per cycle, so items that
// close two segments fill the queue faster than it drains.
// A stalled receiver fills the queue; the input register then holds once
// fewer than two entries are free, and in_ready drops.
// Reset clears the nesting state, segment start, queue and input register,
// and loads the delimiter, list open and list close registers with ',', '['
// and ']'. Write them through cfg_we/cfg_index/cfg_data while idle.
module nesting_aware_delimiter_splitter #(
	parameter int DEPTH_BITS = 8,
	parameter int POS_BITS   = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [7:0]                       ch,
	input  logic [15:0]                      position,
	input  logic                             first,
	input  logic                             last,
	input  logic                             empty_req,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [15:0]                      seg_start,
	output logic [15:0]                      seg_length,
	output logic                             final_segment,
	input  logic                             cfg_we,
	input  logic [nads_pkg::CFG_IDX_BITS-1:0] cfg_index,
	input  logic [7:0]                       cfg_data
);
	import nads_pkg::*;

	cfg_t      cfg_q;
	item_t     item_s1;
	logic      valid_s1;
	logic      adv_s1, room;
	scan_res_t res;
	seg_t      head;

	assign adv_s1   = valid_s1 && room;
	assign in_ready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.delimiter  <= RST_DELIMITER;
			cfg_q.list_open  <= RST_LIST_OPEN;
			cfg_q.list_close <= RST_LIST_CLOSE;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_DELIMITER:  cfg_q.delimiter  <= cfg_data;
				CFG_LIST_OPEN:  cfg_q.list_open  <= cfg_data;
				CFG_LIST_CLOSE: cfg_q.list_close <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= '{ch: ch, position: position, first: first, last: last,
				empty_req: empty_req};
		end
	end

	nads_scan #(
		.DEPTH_BITS(DEPTH_BITS),
		.POS_BITS  (POS_BITS)
	) u_scan (
		.clk   (clk),
		.arst_n(arst_n),
		.en    (adv_s1),
		.item  (item_s1),
		.cfg   (cfg_q),
		.res   (res)
	);

	nads_outq u_outq (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (adv_s1),
		.res      (res),
		.room     (room),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.head     (head)
	);

	assign seg_start     = head.start;
	assign seg_length    = head.length;
	assign final_segment = head.fin;

endmodule

// File: rtl/nads_scan.sv
// Nesting and quote tracker that turns one character item into up to two segments.
module nads_scan #(
	parameter int DEPTH_BITS = 8,
	parameter int POS_BITS   = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  nads_pkg::item_t    item,
	input  nads_pkg::cfg_t     cfg,
	output nads_pkg::scan_res_t res
);
	import nads_pkg::*;

	logic [DEPTH_BITS-1:0] list_depth_q, brace_depth_q;
	logic                  in_dq_q, in_sq_q;
	logic [POS_BITS-1:0]   seg_begin_q;

	logic [DEPTH_BITS-1:0] list_d, brace_d;
	logic                  dq_d, sq_d;
	logic [POS_BITS-1:0]   begin_d, begin_b, pos, len_delim, len_last;
	logic                  top_level, delim_hit;

	always_comb begin
		pos       = POS_BITS'(item.position);
		list_d    = item.first ? '0 : list_depth_q;
		brace_d   = item.first ? '0 : brace_depth_q;
		dq_d      = item.first ? 1'b0 : in_dq_q;
		sq_d      = item.first ? 1'b0 : in_sq_q;
		begin_b   = item.first ? pos : seg_begin_q;
		top_level = (list_d == '0) && (brace_d == '0) && !dq_d && !sq_d;
		delim_hit = 1'b0;
		priority if (item.ch == cfg.list_open) begin
			list_d = list_d + DEPTH_BITS'(1);
		end else if (item.ch == cfg.list_close) begin
			list_d = list_d - DEPTH_BITS'(1);
		end else if (item.ch == CH_BRACE_OPEN) begin
			brace_d = brace_d + DEPTH_BITS'(1);
		end else if (item.ch == CH_BRACE_CLOSE) begin
			brace_d = brace_d - DEPTH_BITS'(1);
		end else if (item.ch == CH_SQUOTE) begin
			sq_d = !sq_d;
		end else if (item.ch == CH_DQUOTE) begin
			dq_d = !dq_d;
		end else begin
			delim_hit = top_level && (item.ch == cfg.delimiter);
		end
		len_delim = pos - begin_b;
		begin_d   = delim_hit ? pos + POS_BITS'(1) : begin_b;
		len_last  = pos - begin_d + POS_BITS'(1);

		res.seg0.start  = 16'(begin_b);
		res.seg0.length = 16'(len_delim);
		res.seg0.fin    = 1'b0;
		res.seg1.start  = 16'(begin_d);
		res.seg1.length = 16'(len_last);
		res.seg1.fin    = 1'b1;
		res.count       = {1'b0, delim_hit} + {1'b0, item.last};
		if (!delim_hit) begin
			res.seg0 = res.seg1;
		end

		if (item.empty_req) begin
			list_d          = '0;
			brace_d         = '0;
			dq_d            = 1'b0;
			sq_d            = 1'b0;
			begin_d         = pos;
			res.seg0.start  = 16'(pos);
			res.seg0.length = 16'd0;
			res.seg0.fin    = 1'b1;
			res.count       = 2'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			list_depth_q  <= '0;
			brace_depth_q <= '0;
			in_dq_q       <= 1'b0;
			in_sq_q       <= 1'b0;
			seg_begin_q   <= '0;
		end else if (en) begin
			list_depth_q  <= list_d;
			brace_depth_q <= brace_d;
			in_dq_q       <= dq_d;
			in_sq_q       <= sq_d;
			seg_begin_q   <= begin_d;
		end
	end

endmodule

// File: rtl/nads_outq.sv
// Small result queue that takes up to two segments a cycle and hands out one.
module nads_outq (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  nads_pkg::scan_res_t res,
	output logic                room,
	output logic                out_valid,
	input  logic                out_ready,
	output nads_pkg::seg_t      head
);
	import nads_pkg::*;

	localparam int DEPTH = 4;
	localparam int AW    = $clog2(DEPTH);

	seg_t          mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [AW:0]   count_q;
	logic [1:0]    n_push;
	logic          pop;

	assign n_push    = push ? res.count : 2'd0;
	assign pop       = out_valid && out_ready;
	assign out_valid = (count_q != '0);
	assign room      = (count_q <= (AW+1)'(DEPTH - 2));
	assign head      = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (n_push != 2'd0) begin
			mem_q[wr_ptr_q] <= res.seg0;
		end
		if (n_push == 2'd2) begin
			mem_q[wr_ptr_q + AW'(1)] <= res.seg1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + AW'(n_push);
			rd_ptr_q <= rd_ptr_q + AW'(pop);
			count_q  <= count_q + (AW+1)'(n_push) - (AW+1)'(pop);
		end
	end

endmodule

// File: rtl/nads_checker.sv
// Port-level checks for the nesting-aware delimiter splitter, bound to the top level.
module nads_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        last,
	input logic        empty_req,
	input logic        out_valid,
	input logic        out_ready,
	input logic [15:0] seg_start,
	input logic [15:0] seg_length,
	input logic        final_segment
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("out_valid dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(seg_start) && $stable(seg_length)
			&& $stable(final_segment))
		else $error("stalled item changed");

	a_ready_when_drained: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input held with empty result queue");

	a_closing_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (last || empty_req) |-> ##2 out_valid)
		else $error("closing item gave no result in time");

endmodule

bind nesting_aware_delimiter_splitter nads_checker u_nads_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_ready     (in_ready),
	.last         (last),
	.empty_req    (empty_req),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.seg_start    (seg_start),
	.seg_length   (seg_length),
	.final_segment(final_segment)
);
